// ===== hdl/assert_macros.svh =====
// Assertion helpers, clocked on aclk and held off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

`define DEQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/deq_pkg.sv =====
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_DUMP_FWD   = 3'd4;
    localparam logic [2:0] REQ_DUMP_BWD   = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] push_value;
    } deq_in_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [1:0]         status;
        logic               last_result;
    } deq_out_t;

    typedef enum logic [2:0] {
        CH_HOLD,
        CH_PUSH_BACK,
        CH_PUSH_FRONT,
        CH_POP_FRONT,
        CH_ROT_FWD,
        CH_ROT_BWD
    } chain_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        chain_op_t          op;
        logic [CNT_W-1:0]   count;
        logic signed [31:0] push_value;
        logic signed [31:0] wrap_value;
    } chain_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

endpackage

// ===== hdl/deq_cell.sv =====
module deq_cell import deq_pkg::*; (
    input  logic               aclk,
    input  chain_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]   cell_index,
    input  logic signed [31:0] left_value,
    input  logic signed [31:0] right_value,
    output logic signed [31:0] value
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic [CNT_W-1:0]   pos;
    logic               in_use;
    logic               is_back;

    always_comb begin
        pos     = CNT_W'(cell_index);
        in_use  = pos < ctrl.count;
        is_back = (pos + CNT_W'(1)) == ctrl.count;
        value_next = value_reg;
        case (ctrl.op)
            CH_PUSH_BACK: begin
                if (pos == ctrl.count) begin
                    value_next = ctrl.push_value;
                end
            end
            CH_PUSH_FRONT: begin
                value_next = (pos == '0) ? ctrl.push_value : left_value;
            end
            CH_POP_FRONT: begin
                value_next = right_value;
            end
            // front word moves to the back, the rest step toward the front
            CH_ROT_FWD: begin
                if (is_back) begin
                    value_next = ctrl.wrap_value;
                end else if (in_use) begin
                    value_next = right_value;
                end
            end
            // back word moves to the front, the rest step toward the back
            CH_ROT_BWD: begin
                if (pos == '0) begin
                    value_next = ctrl.wrap_value;
                end else if (in_use) begin
                    value_next = left_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== hdl/double_ended_queue_core.sv =====
// Double-ended queue of signed 32-bit words held in a chain of DEPTH cells, the front
// word always in cell 0. Pushes and pops take one input word and return one result word
// in the cycle after acceptance; with the output taken every cycle they run at one word
// per cycle. A dump of N stored words returns N results, one per cycle while the output
// is taken, as the chain rotates one position per result (it is back in its original
// order when the dump ends); no input is taken during a dump. A push to a full
// queue returns status full, a pop or dump of an empty queue returns status empty, and
// request codes 6 and 7 are taken and dropped without a result.
`include "assert_macros.svh"

module double_ended_queue_core import deq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  deq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output deq_out_t m_data
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] remaining_reg, remaining_next;
    logic             dump_bwd_reg, dump_bwd_next;
    logic             m_valid_reg, m_valid_next;
    deq_out_t         m_data_reg, m_data_next;

    logic signed [31:0] cell_value [DEPTH];
    logic [IDX_W-1:0]   back_idx;
    logic signed [31:0] back_value;
    logic [CNT_W-1:0]   count_dec;
    logic               out_free;
    logic               accept;
    logic               is_empty;
    logic               is_full;
    chain_ctrl_t        ctrl;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign is_empty  = count_reg == '0;
    assign is_full   = count_reg == CNT_W'(DEPTH);
    assign count_dec = count_reg - CNT_W'(1);
    assign back_idx  = count_dec[IDX_W-1:0];
    assign back_value = cell_value[back_idx];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [31:0] left_w;
            logic signed [31:0] right_w;
            if (gi == 0) begin : g_first
                assign left_w = s_data.push_value;
            end else begin : g_mid_l
                assign left_w = cell_value[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right_w = cell_value[gi];
            end else begin : g_mid_r
                assign right_w = cell_value[gi+1];
            end
            deq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .cell_index  (IDX_W'(gi)),
                .left_value  (left_w),
                .right_value (right_w),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    // next state
    always_comb begin
        state_next     = state_reg;
        remaining_next = remaining_reg;
        dump_bwd_next  = dump_bwd_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !is_empty &&
                    (s_data.req_type == REQ_DUMP_FWD || s_data.req_type == REQ_DUMP_BWD)) begin
                    state_next     = ST_DUMP;
                    remaining_next = count_reg;
                    dump_bwd_next  = s_data.req_type == REQ_DUMP_BWD;
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    remaining_next = remaining_reg - CNT_W'(1);
                    if (remaining_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs, chain control and count
    always_comb begin
        count_next      = count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ctrl.op         = CH_HOLD;
        ctrl.count      = count_reg;
        ctrl.push_value = s_data.push_value;
        ctrl.wrap_value = dump_bwd_reg ? back_value : cell_value[0];
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_data_next.out_value   = '0;
                    m_data_next.status      = STATUS_OK;
                    m_data_next.last_result = 1'b1;
                    unique case (s_data.req_type) inside
                        REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                            m_valid_next = 1'b1;
                            if (is_full) begin
                                m_data_next.status = STATUS_FULL;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                                ctrl.op = (s_data.req_type == REQ_PUSH_BACK) ?
                                          CH_PUSH_BACK : CH_PUSH_FRONT;
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            m_valid_next = 1'b1;
                            if (is_empty) begin
                                m_data_next.status = STATUS_EMPTY;
                            end else begin
                                count_next = count_dec;
                                if (s_data.req_type == REQ_POP_FRONT) begin
                                    m_data_next.out_value = cell_value[0];
                                    ctrl.op = CH_POP_FRONT;
                                end else begin
                                    m_data_next.out_value = back_value;
                                end
                            end
                        end
                        REQ_DUMP_FWD, REQ_DUMP_BWD: begin
                            // non-empty dumps emit from the dump state
                            if (is_empty) begin
                                m_valid_next       = 1'b1;
                                m_data_next.status = STATUS_EMPTY;
                            end
                        end
                        default: begin
                            m_data_next = m_data_reg;
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.out_value   = ctrl.wrap_value;
                    m_data_next.status      = STATUS_OK;
                    m_data_next.last_result = remaining_reg == CNT_W'(1);
                    ctrl.op = dump_bwd_reg ? CH_ROT_BWD : CH_ROT_FWD;
                end
            end
            default: begin
                ctrl.op = CH_HOLD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remaining_reg <= '0;
            dump_bwd_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
            dump_bwd_reg  <= dump_bwd_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `DEQ_ASSERT(a_count_range, count_reg <= CNT_W'(DEPTH), "element count above depth")
    `DEQ_ASSERT_IMPL(a_dump_remaining, state_reg == ST_DUMP,
        (remaining_reg != '0) && (remaining_reg <= count_reg), "dump word count out of range")
    `DEQ_ASSERT_IMPL(a_dump_blocks_input, state_reg == ST_DUMP, !s_ready,
        "input taken during dump")
    `DEQ_ASSERT_NEXT(a_full_push_dropped,
        accept && is_full && (s_data.req_type == REQ_PUSH_BACK ||
        s_data.req_type == REQ_PUSH_FRONT), $stable(count_reg), "push into full queue stored")

endmodule
